### src/mrr_pkg.sv
// Shared types and constants for the Miller-Rabin round unit.
package mrr_pkg;

   localparam int NUM_BITS_DEF = 31;

   // Datapath commands issued by the controller
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_LOAD  = 3'd1,   // latch n, a; set acc=1, e=n-1
      CMD_SHIFT = 3'd2,   // strip one trailing zero of d
      CMD_MUL   = 3'd3,   // start acc*base mod n
      CMD_SQB   = 3'd4,   // start base*base mod n
      CMD_SQX   = 3'd5,   // start acc*acc mod n
      CMD_REDA  = 3'd6    // start a mod n (witness reduction)
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic mul_done;   // modular unit finished
      logic d_even;     // exponent still even during split
      logic e_zero;     // exponent exhausted
      logic e_lsb;      // exponent low bit
      logic x_one;      // acc == 1
      logic x_nm1;      // acc == n-1
      logic r_left;     // squarings remain (r > 1)
      logic small_res;  // result for small/even candidates
      logic small_hit;  // candidate decided directly
   } sts_type;

endpackage

### src/miller_rabin_round_unit.sv
// Top level of the Miller-Rabin round unit.
// Usage:
//   Input word: req_candidate (n) and req_witness (a), taken when req_valid
//   is high and req_stall is low. One result word per input word on rsp_:
//   rsp_probably_prime, held while rsp_stall is high.
//   Candidates 0..4 and even n are decided at once, the result registered in
//   the cycle after they are taken. Otherwise the word runs the split, the
//   witness reduction, the exponentiation and the squaring loop. Each
//   multiplication runs in a single shift-add-reduce unit, one multiplier
//   bit per cycle.
//   One word is worked on at a time; req_stall is high while busy or
//   while an untaken result remains.
//   Reset (synchronous, active high) returns to idle and drops any
//   pending result.
module miller_rabin_round_unit import mrr_pkg::*; #(
   parameter int NUM_BITS = NUM_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [NUM_BITS-1:0] req_candidate,
   input  logic [NUM_BITS-1:0] req_witness,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_probably_prime
);

   ctl_type ctl;
   sts_type sts;

   mrr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_probably_prime, .ctl, .sts
   );

   mrr_datapath #(.NUM_BITS(NUM_BITS)) u_dp (
      .clock, .reset, .ctl, .cand(req_candidate), .wit(req_witness), .sts
   );

`ifndef SYNTHESIS
   // No new word accepted while a result waits
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept with pending result");
   // A result leaves only after it is taken
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   // Even large candidates are reported composite at once
   a_even: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_candidate[0] && req_candidate > 4)
      |=> (rsp_valid && !rsp_probably_prime)) else $error("even not composite");
`endif

endmodule

### src/mrr_datapath.sv
// Datapath: operand registers, exponent split and shift-add modular multiplier.
module mrr_datapath import mrr_pkg::*; #(
   parameter int NUM_BITS = NUM_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   input  logic [NUM_BITS-1:0] cand,
   input  logic [NUM_BITS-1:0] wit,
   output sts_type             sts
);

   localparam int CW = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] n_ff, n_in, acc_ff, acc_in, base_ff, base_in, e_ff, e_in;
   // witness held from the accepted word
   logic [NUM_BITS-1:0] a_ff, a_in;
   logic [CW-1:0]       r_ff, r_in;
   // multiplier state: product built MSB first, p kept below n
   logic [NUM_BITS:0]   p_ff, p_in;
   logic [NUM_BITS-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [CW-1:0]       mcnt_ff, mcnt_in;
   logic                busy_ff, busy_in;
   logic [1:0]          dst_ff, dst_in;   // 0 acc, 1 base

   logic [NUM_BITS+1:0] dbl, add1;
   logic [NUM_BITS+1:0] nn;
   logic [NUM_BITS:0]   step;

   assign nn = {2'b00, n_ff};

   // one shift-add-reduce step (p < n so 2p+b < 3n)
   always_comb begin
      dbl = {p_ff, 1'b0};
      if (dbl >= nn) dbl = dbl - nn;
      add1 = dbl + (ma_ff[NUM_BITS-1] ? {2'b00, mb_ff} : '0);
      if (add1 >= nn) add1 = add1 - nn;
      step = add1[NUM_BITS:0];
   end

   always_comb begin
      n_in = n_ff; acc_in = acc_ff; base_in = base_ff; e_in = e_ff; r_in = r_ff;
      a_in = a_ff;
      p_in = p_ff; ma_in = ma_ff; mb_in = mb_ff; mcnt_in = mcnt_ff;
      busy_in = busy_ff; dst_in = dst_ff;
      if (busy_ff) begin
         p_in = step;
         ma_in = {ma_ff[NUM_BITS-2:0], 1'b0};
         mcnt_in = mcnt_ff - 1'b1;
         if (mcnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            if (dst_ff == 2'd0) acc_in = step[NUM_BITS-1:0];
            else base_in = step[NUM_BITS-1:0];
         end
      end
      case (ctl.cmd) inside
         CMD_LOAD: begin
            n_in = cand; a_in = wit; acc_in = NUM_BITS'(1);
            e_in = cand - 1'b1; r_in = '0;
         end
         CMD_SHIFT: begin
            e_in = e_ff >> 1; r_in = r_ff + 1'b1;
         end
         CMD_REDA, CMD_MUL, CMD_SQB, CMD_SQX: begin
            busy_in = 1'b1; p_in = '0; mcnt_in = CW'(NUM_BITS);
            dst_in = (ctl.cmd == CMD_MUL || ctl.cmd == CMD_SQX) ? 2'd0 : 2'd1;
            ma_in = (ctl.cmd == CMD_SQB) ? base_ff :
                    (ctl.cmd == CMD_REDA) ? a_ff : acc_ff;
            mb_in = (ctl.cmd == CMD_MUL) ? base_ff :
                    (ctl.cmd == CMD_SQB) ? base_ff :
                    (ctl.cmd == CMD_SQX) ? acc_ff : NUM_BITS'(1);
            // base squaring consumes one exponent bit; acc squaring uses up one of r
            if (ctl.cmd == CMD_SQB) e_in = e_ff >> 1;
            if (ctl.cmd == CMD_SQX) r_in = r_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; acc_ff <= acc_in; base_ff <= base_in; e_ff <= e_in; r_ff <= r_in;
      a_ff <= a_in;
      p_ff <= p_in; ma_ff <= ma_in; mb_ff <= mb_in; mcnt_ff <= mcnt_in; dst_ff <= dst_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   // status back to the controller
   always_comb begin
      sts.mul_done = ~busy_ff;
      sts.d_even   = ~e_ff[0];
      sts.e_zero   = (e_ff == '0);
      sts.e_lsb    = e_ff[0];
      sts.x_one    = (acc_ff == NUM_BITS'(1));
      sts.x_nm1    = (acc_ff == n_ff - 1'b1);
      sts.r_left   = (r_ff > CW'(1));
      sts.small_hit = (cand <= NUM_BITS'(4)) || ~cand[0];
      sts.small_res = (cand == NUM_BITS'(2)) || (cand == NUM_BITS'(3));
   end

endmodule

### src/mrr_ctrl.sv
// Controller: decides small candidates, sequences split, witness reduction, exponentiation and squaring loop.
module mrr_ctrl import mrr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_probably_prime,
   output ctl_type ctl,
   input  sts_type sts
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SPLIT = 9'b000000010,
      S_REDA  = 9'b000000100,
      S_POW   = 9'b000001000,
      S_MULW  = 9'b000010000,
      S_SQBW  = 9'b000100000,
      S_CHK   = 9'b001000000,
      S_SQXW  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      res_ff, res_in, vld_ff, vld_in, first_ff, first_in;

   assign req_stall = (state_ff != S_IDLE) || vld_ff;
   assign rsp_valid = vld_ff;
   assign rsp_probably_prime = res_ff;

   // advance the sequencer
   always_comb begin
      state_in = state_ff; res_in = res_ff; vld_in = vld_ff; first_in = first_ff;
      ctl.cmd = CMD_NONE;
      if (vld_ff && !rsp_stall) vld_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid && !vld_ff) begin
            if (sts.small_hit) begin
               res_in = sts.small_res; vld_in = 1'b1;
            end else begin
               ctl.cmd = CMD_LOAD; state_in = S_SPLIT;
            end
         end
         S_SPLIT: if (sts.d_even) ctl.cmd = CMD_SHIFT;
            else begin ctl.cmd = CMD_REDA; state_in = S_REDA; end
         S_REDA: if (sts.mul_done) state_in = S_POW;
         S_POW: if (sts.e_zero) begin
               first_in = 1'b1; state_in = S_CHK;
            end else if (sts.e_lsb) begin ctl.cmd = CMD_MUL; state_in = S_MULW; end
            else begin ctl.cmd = CMD_SQB; state_in = S_SQBW; end
         S_MULW: if (sts.mul_done) begin ctl.cmd = CMD_SQB; state_in = S_SQBW; end
         S_SQBW: if (sts.mul_done) state_in = S_POW;
         S_CHK: begin
            first_in = 1'b0;
            if (sts.x_nm1) begin res_in = 1'b1; state_in = S_DONE; end
            else if (sts.x_one) begin res_in = first_ff; state_in = S_DONE; end
            else if (!sts.r_left) begin res_in = 1'b0; state_in = S_DONE; end
            else begin ctl.cmd = CMD_SQX; state_in = S_SQXW; end
         end
         S_SQXW: if (sts.mul_done) state_in = S_CHK;
         S_DONE: if (!vld_ff) begin vld_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0; res_ff <= 1'b0; first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in; res_ff <= res_in; first_ff <= first_in;
      end
   end

endmodule

### tb/sv/tb_top.sv
// Testbench for the Miller-Rabin round unit: directed table, then random words.
module tb_top;
   import mrr_pkg::*;

   localparam int NB        = NUM_BITS_DEF;
   localparam int RAND_WORDS = 200;
   localparam int WDOG_LIMIT = 20000;
   localparam int PHASE_LEN  = 50;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [NB-1:0] req_candidate;
   logic [NB-1:0] req_witness;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_probably_prime;

   // verdicts still owed by the block, oldest first
   bit verdict_q[$];
   int err_count = 0;
   int phase;
   int wdog;

   typedef struct {
      bit [NB-1:0] n;
      bit [NB-1:0] a;
      bit          known;
      bit          verdict;
   } row_type;

   miller_rabin_round_unit #(.NUM_BITS(NB)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_candidate(req_candidate), .req_witness(req_witness),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_probably_prime(rsp_probably_prime)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // One Miller-Rabin round on 64-bit arithmetic
   function automatic bit round_passes(bit [NB-1:0] n_in, bit [NB-1:0] a_in);
      longint unsigned n, nm1, d, x, b, e;
      int r;
      int i;
      n = n_in;
      if (n <= 1 || n == 4) return 1'b0;
      if (n <= 3) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      nm1 = n - 1;
      d = nm1;
      r = 0;
      while (d[0] == 1'b0) begin
         d = d >> 1;
         r++;
      end
      // square-and-multiply for a^d mod n
      x = 1;
      b = longint'(a_in) % n;
      e = d;
      while (e != 0) begin
         if (e[0]) x = (x * b) % n;
         e = e >> 1;
         b = (b * b) % n;
      end
      if (x == 1 || x == nm1) return 1'b1;
      for (i = 1; i < r; i++) begin
         x = (x * x) % n;
         if (x == 1) return 1'b0;
         if (x == nm1) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Present one word, hold it until taken, then queue its verdict
   task automatic send_word(bit [NB-1:0] n, bit [NB-1:0] a, bit verdict);
      int idle_pct;
      idle_pct = (phase == 1) ? 64 : (phase == 3) ? 7 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_candidate <= n;
      req_witness   <= a;
      do @(posedge clock); while (req_stall);
      verdict_q.push_back(verdict);
   endtask

   // Stall the result side, check words, watch for a hang
   always @(posedge clock) begin
      int stall_pct;
      stall_pct = (phase == 2) ? 64 : (phase == 3) ? 7 : 0;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (reset) begin
         wdog <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected word: probably_prime=%0b", rsp_probably_prime);
               err_count++;
            end else begin
               bit want;
               want = verdict_q.pop_front();
               if (rsp_probably_prime !== want) begin
                  $error("probably_prime: expected %0b, actual %0b", want,
                         rsp_probably_prime);
                  err_count++;
               end
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            wdog <= 0;
         end else if (wdog + 1 >= WDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            wdog <= wdog + 1;
         end
      end
   end

   initial begin
      row_type rows[$];
      bit [NB-1:0] n, a;
      int unsigned v;
      bit is_p;
      int k;
      phase = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_candidate <= '0;
      req_witness <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: small candidates, evens, extremes, witness edge cases
      rows = '{
         '{0, 5, 1, 0}, '{1, 2, 1, 0}, '{2, 0, 1, 1}, '{3, 7, 1, 1}, '{4, 3, 1, 0},
         '{6, 2, 1, 0}, '{31'h7FFF_FFFE, 31'h7FFF_FFFF, 1, 0},
         '{7, 14, 1, 0}, '{7, 1, 1, 1}, '{7, 6, 1, 1}, '{7, 8, 1, 1},
         '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 0}, '{31'h7FFF_FFFF, 2, 0, 0},
         '{31'h7FFF_FFFF, 31'h7FFF_FFFD, 0, 0}, '{561, 2, 0, 0}, '{2047, 2, 0, 0},
         '{341, 2, 0, 0}, '{9, 2, 0, 0}, '{25, 7, 0, 0}, '{65, 8, 0, 0},
         '{31'h7FFF_FFFD, 31'h5555_5555, 0, 0}, '{31'h2AAA_AAAB, 3, 0, 0},
         '{104729, 31'h1234_5678, 0, 0}
      };
      foreach (rows[i])
         send_word(rows[i].n, rows[i].a,
                   rows[i].known ? rows[i].verdict : round_passes(rows[i].n, rows[i].a));

      // random: small primes, odd candidates of random length, raw noise
      for (k = 0; k < RAND_WORDS; k++) begin
         phase = (k / PHASE_LEN) % 4;
         case ($urandom_range(9)) inside
            [0:2]: begin
               do begin
                  v = $urandom_range(65535, 5);
                  is_p = 1'b1;
                  for (int unsigned f = 2; f * f <= v; f++)
                     if (v % f == 0) is_p = 1'b0;
               end while (!is_p);
               n = NB'(v);
            end
            9: n = NB'($urandom);
            default: begin
               n = NB'($urandom >> (32 - $urandom_range(NB, 3)));
               n[0] = 1'b1;
            end
         endcase
         if (n > 4 && $urandom_range(9) < 8) a = NB'($urandom_range(n - 2, 2));
         else a = NB'($urandom);
         send_word(n, a, round_passes(n, a));
      end
      req_valid <= 1'b0;
      phase = 0;

      // drain, then settle
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
